>>> rtl/rcs_pkg.sv
// Shared constants and types of the column ray setup block.
`default_nettype none
package rcs_pkg;

   localparam int SCREEN_WIDTH_DEF = 640;
   localparam int MAP_CELLS_DEF    = 256;

   // Configuration register indexes
   localparam logic [2:0] REG_POS_X   = 3'd0;
   localparam logic [2:0] REG_POS_Y   = 3'd1;
   localparam logic [2:0] REG_DIR_X   = 3'd2;
   localparam logic [2:0] REG_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_PLANE_X = 3'd4;
   localparam logic [2:0] REG_PLANE_Y = 3'd5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int RAY_W  = 17;
   localparam int DIST_W = 32;

   localparam logic signed [RAY_W-1:0] RAY_MIN = -17'sd65536;
   localparam logic signed [RAY_W-1:0] RAY_MAX = 17'sd65535;
   localparam logic [DIST_W-1:0]       DIST_MAX = '1;

   // Reciprocal divider: 2^30 / |ray|, two quotient bits per stage
   localparam int DIV_W          = 32;
   localparam int DIV_ONE_BIT    = 30;
   localparam int DIV_PER_STAGE  = 2;
   localparam int DIV_STAGES     = DIV_W / DIV_PER_STAGE;

   typedef logic signed [RAY_W-1:0] ray_type;

endpackage
`default_nettype wire

>>> rtl/rcs_if.sv
// Request and response channel interfaces of the column ray setup block.
`default_nettype none
interface rcs_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] column;
   modport source (output valid, output column, input ready);
   modport sink   (input valid, input column, output ready);
endinterface

interface rcs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] ray_x;
   logic signed [16:0] ray_y;
   logic [7:0]         cell_x;
   logic [7:0]         cell_y;
   logic               step_x_neg;
   logic               step_y_neg;
   logic [31:0]        delta_x;
   logic [31:0]        delta_y;
   logic [31:0]        side_x;
   logic [31:0]        side_y;
   modport source (output valid, output ray_x, output ray_y, output cell_x, output cell_y,
                   output step_x_neg, output step_y_neg, output delta_x, output delta_y,
                   output side_x, output side_y, input ready);
   modport sink   (input valid, input ray_x, input ray_y, input cell_x, input cell_y,
                   input step_x_neg, input step_y_neg, input delta_x, input delta_y,
                   input side_x, input side_y, output ready);
endinterface
`default_nettype wire

>>> rtl/raycast_column_ray_setup.sv
// Top level of the column ray setup block: camera ray, map cell, step, delta and side distances.
// Throughput: one column word per cycle unless the response stalls; the 16-stage reciprocal divider is fully pipelined.
// A stalled response holds the whole pipeline in place; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits and loads the default view registers.
`default_nettype none
module raycast_column_ray_setup
   import rcs_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int MAP_CELLS    = MAP_CELLS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rcs_req_if.sink                    req_if,
   rcs_rsp_if.source                  rsp_if,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Rounded camera term divides by 2*W: reciprocal multiply plus one correction
   localparam logic [13:0] DIV_D = 14'(2 * SCREEN_WIDTH);
   localparam logic [28:0] RECIP = 29'((64'd1 << 30) / (2 * SCREEN_WIDTH));
   localparam logic [7:0]  CELL_TOP = 8'(256 % MAP_CELLS);

   // ---------------- configuration registers ----------------
   logic [15:0]        pos_x_ff, pos_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dir_x_ff   <= 16'sd16384;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 16'sd10813;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_POS_X:   pos_x_ff   <= csr_wdata;
            REG_POS_Y:   pos_y_ff   <= csr_wdata;
            REG_DIR_X:   dir_x_ff   <= $signed(csr_wdata);
            REG_DIR_Y:   dir_y_ff   <= $signed(csr_wdata);
            REG_PLANE_X: plane_x_ff <= $signed(csr_wdata);
            REG_PLANE_Y: plane_y_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   logic [15:0]        pos_a   [2];
   logic signed [15:0] dir_a   [2];
   logic signed [15:0] plane_a [2];
   assign pos_a[0]   = pos_x_ff;
   assign pos_a[1]   = pos_y_ff;
   assign dir_a[0]   = dir_x_ff;
   assign dir_a[1]   = dir_y_ff;
   assign plane_a[0] = plane_x_ff;
   assign plane_a[1] = plane_y_ff;

   // whole pipeline moves when the response register is free or being drained
   logic adv;
   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;

   // ---------------- valid chain ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, vo_ff;
   logic [1:0] dv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_if.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         vo_ff <= dv[0];
      end
   end

   // stage 1: capture column
   logic [11:0] col_ff;
   always_ff @(posedge clock) begin
      if (adv) col_ff <= req_if.column;
   end

   // 2*column - W, shared by both axes
   logic signed [13:0] cam_t;
   assign cam_t = $signed({1'b0, col_ff, 1'b0}) - $signed(14'(SCREEN_WIDTH));

   // cell index from the position registers: (pos + 1/2) >> 8 mod MAP_CELLS
   logic [7:0] cell_lut [256];
   for (genvar g = 0; g < 256; g++) begin : g_lut
      assign cell_lut[g] = 8'(g % MAP_CELLS);
   end

   ray_type           o_ray   [2];
   logic [7:0]        o_cell  [2];
   logic [DIST_W-1:0] o_delta [2];
   logic [DIST_W-1:0] o_side  [2];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic signed [29:0] num_ff;
      logic signed [30:0] n_sum;
      logic [29:0]        a_ff, a4_ff;
      logic               neg3_ff, neg4_ff, neg5_ff;
      logic [58:0]        recip_prod;
      logic [28:0]        q0_ff;
      logic [42:0]        back_prod;
      logic [42:0]        rem_est;
      logic [28:0]        q_ff;
      logic signed [30:0] ray_sum;
      ray_type            ray_sat;
      ray_type            ray_ff;
      logic [16:0]        mag;
      logic [DIV_W-1:0]   quot;
      logic [RAY_W-1:0]   dtag;
      logic               dneg;
      logic               dzero;
      logic [7:0]         frac;
      logic [8:0]         f_mul;
      logic [40:0]        side_prod;
      logic [8:0]         cell9;
      ray_type            ray_o_ff;
      logic [7:0]         cell_o_ff;
      logic [DIST_W-1:0]  delta_o_ff, side_o_ff;

      // stage 2: plane * (2c - W), full-width signed product
      always_ff @(posedge clock) begin
         if (adv) num_ff <= 30'(plane_a[a]) * 30'(cam_t);
      end

      // stage 3: numerator 2*num + W, fold sign so floor becomes unsigned division
      assign n_sum = $signed({num_ff, 1'b0}) + $signed(31'(SCREEN_WIDTH));
      always_ff @(posedge clock) begin
         if (adv) begin
            neg3_ff <= n_sum[30];
            a_ff    <= n_sum[30] ? 30'(-n_sum + $signed(31'(DIV_D - 14'd1))) : 30'(n_sum);
         end
      end

      // stage 4: quotient estimate by reciprocal, low by at most one
      assign recip_prod = 59'(a_ff) * 59'(RECIP);
      always_ff @(posedge clock) begin
         if (adv) begin
            q0_ff   <= recip_prod[58:30];
            a4_ff   <= a_ff;
            neg4_ff <= neg3_ff;
         end
      end

      // stage 5: correction step
      assign back_prod = 43'(q0_ff) * 43'(DIV_D);
      assign rem_est   = 43'(a4_ff) - back_prod;
      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff    <= q0_ff + 29'(rem_est >= 43'(DIV_D));
            neg5_ff <= neg4_ff;
         end
      end

      // stage 6: ray = dir +/- q, saturated
      assign ray_sum = 31'(dir_a[a]) + (neg5_ff ? -$signed({2'b0, q_ff}) : $signed({2'b0, q_ff}));
      always_comb begin
         if (ray_sum < 31'(RAY_MIN)) ray_sat = RAY_MIN;
         else if (ray_sum > 31'(RAY_MAX)) ray_sat = RAY_MAX;
         else ray_sat = ray_sum[16:0];
      end
      always_ff @(posedge clock) begin
         if (adv) ray_ff <= ray_sat;
      end
      assign mag = ray_ff[16] ? 17'(-ray_ff) : ray_ff;

      // stages 7..22: reciprocal 2^30 / |ray|
      rcs_div #(.TAG_W(RAY_W)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (v6_ff),
         .in_mag    (mag),
         .in_tag    (ray_ff),
         .out_valid (dv[a]),
         .out_quot  (quot),
         .out_tag   (dtag)
      );

      // stage 23: side distance and response register
      assign dneg  = dtag[16];
      assign dzero = (dtag == '0);
      assign frac  = {~pos_a[a][7], pos_a[a][6:0]};
      assign f_mul = dneg ? {1'b0, frac} : 9'd256 - {1'b0, frac};
      assign side_prod = 41'(f_mul) * 41'(quot);
      assign cell9 = {1'b0, pos_a[a][15:8]} + 9'(pos_a[a][7]);

      always_ff @(posedge clock) begin
         if (adv) begin
            ray_o_ff   <= $signed(dtag);
            cell_o_ff  <= cell9[8] ? CELL_TOP : cell_lut[cell9[7:0]];
            delta_o_ff <= dzero ? DIST_MAX : quot;
            if (dzero || side_prod[40]) side_o_ff <= DIST_MAX;
            else side_o_ff <= side_prod[39:8];
         end
      end

      assign o_ray[a]   = ray_o_ff;
      assign o_cell[a]  = cell_o_ff;
      assign o_delta[a] = delta_o_ff;
      assign o_side[a]  = side_o_ff;
   end

   assign rsp_if.valid      = vo_ff;
   assign rsp_if.ray_x      = o_ray[0];
   assign rsp_if.ray_y      = o_ray[1];
   assign rsp_if.cell_x     = o_cell[0];
   assign rsp_if.cell_y     = o_cell[1];
   assign rsp_if.step_x_neg = o_ray[0][16];
   assign rsp_if.step_y_neg = o_ray[1][16];
   assign rsp_if.delta_x    = o_delta[0];
   assign rsp_if.delta_y    = o_delta[1];
   assign rsp_if.side_x     = o_side[0];
   assign rsp_if.side_y     = o_side[1];

`ifndef SYNTHESIS
   // both axis dividers carry the same word
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dv[0] == dv[1])
      else $error("divider valid bits out of step");

   // zero ray gives saturated distances
   a_zero_x: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ray_x == '0 |-> rsp_if.delta_x == DIST_MAX &&
      rsp_if.side_x == DIST_MAX)
      else $error("zero ray x without saturated distance");

   a_zero_y: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ray_y == '0 |-> rsp_if.delta_y == DIST_MAX &&
      rsp_if.side_y == DIST_MAX)
      else $error("zero ray y without saturated distance");

   // nonzero x ray: reciprocal stays within 2^14 .. 2^30
   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ray_x != '0 |-> rsp_if.delta_x >= 32'd16384 &&
      rsp_if.delta_x <= 32'h4000_0000)
      else $error("delta x out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/rcs_div.sv
// Pipelined restoring divider computing 2^30 / mag, two quotient bits per stage.
`default_nettype none
module rcs_div
   import rcs_pkg::*;
#(
   parameter int TAG_W = RAY_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [16:0]       in_mag,
   input  wire logic [TAG_W-1:0]  in_tag,
   output logic                   out_valid,
   output logic [DIV_W-1:0]       out_quot,
   output logic [TAG_W-1:0]       out_tag
);

   logic              v_ff    [DIV_STAGES];
   logic [16:0]       mag_ff  [DIV_STAGES];
   logic [16:0]       rem_ff  [DIV_STAGES];
   logic [DIV_W-1:0]  quot_ff [DIV_STAGES];
   logic [TAG_W-1:0]  tag_ff  [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic              src_v;
      logic [16:0]       src_mag;
      logic [16:0]       src_rem;
      logic [DIV_W-1:0]  src_quot;
      logic [TAG_W-1:0]  src_tag;
      logic [16:0]       rem_in;
      logic [DIV_W-1:0]  quot_in;

      if (i == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_mag  = in_mag;
         assign src_rem  = '0;
         assign src_quot = '0;
         assign src_tag  = in_tag;
      end else begin : g_next
         assign src_v    = v_ff[i-1];
         assign src_mag  = mag_ff[i-1];
         assign src_rem  = rem_ff[i-1];
         assign src_quot = quot_ff[i-1];
         assign src_tag  = tag_ff[i-1];
      end

      always_comb begin
         logic [17:0] trial;
         rem_in  = src_rem;
         quot_in = src_quot;
         for (int k = 0; k < DIV_PER_STAGE; k++) begin
            // dividend bit is set only at the 2^30 position
            trial = {rem_in, ((DIV_W - 1 - DIV_PER_STAGE*i - k) == DIV_ONE_BIT)};
            if (trial >= {1'b0, src_mag}) begin
               rem_in = 17'(trial - {1'b0, src_mag});
               quot_in[DIV_W - 1 - DIV_PER_STAGE*i - k] = 1'b1;
            end else begin
               rem_in = trial[16:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= src_v;
         end
         if (en) begin
            mag_ff[i]  <= src_mag;
            rem_ff[i]  <= rem_in;
            quot_ff[i] <= quot_in;
            tag_ff[i]  <= src_tag;
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_quot  = quot_ff[DIV_STAGES-1];
   assign out_tag   = tag_ff[DIV_STAGES-1];

endmodule
`default_nettype wire
